### hw/rtl/sdp_pkg.sv
// Shared types and constants for the softened dipole potential block.
// No dependencies; sdp_pair and softened_dipole_potential import this package.
`timescale 1ns / 1ps

package sdp_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int FRAC_BITS_DEF     = 16;

  localparam int COORD_W = 24;
  localparam int EPS_W   = 24;
  localparam int EPS2_W  = 2 * EPS_W;
  localparam logic [EPS_W-1:0] EPS_RESET = 24'd65536;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int R2_W   = 50;
  localparam int DOT_W  = 50;
  localparam int ROOT_W = 25;

  // pair term magnitude; the cap itself is a legal value
  localparam int Q_W      = 57;
  localparam int Q1_SHIFT = 24;
  localparam logic [Q_W-1:0] TERM_CAP = {1'b1, {(Q_W-1){1'b0}}};

  localparam int ACC_W = Q_W + 6;
  localparam int MAG_W = ACC_W - 1;
  localparam int HI_W  = MAG_W - 32;

  // 1/(4 pi) in Q.32
  localparam int INV_W = 29;
  localparam logic [INV_W-1:0] INV_4PI_Q32 = 29'd341782638;

  localparam int POT_W     = 40;
  localparam int IDX_OUT_W = 6;
  localparam int SCALE_W   = 60;
  localparam logic [SCALE_W-1:0] POT_NEG_LIM = SCALE_W'(1) << (POT_W - 1);
  localparam logic [SCALE_W-1:0] POT_POS_LIM = POT_NEG_LIM - SCALE_W'(1);

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vec_t;

  // position in the low bits, matching the input beat layout
  typedef struct packed {
    vec_t vort;
    vec_t pos;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [Q_W-1:0] mag;
    logic           neg;
    logic           clip;
  } term_t;

endpackage

### hw/rtl/sdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sdp_pair.sv
// Pair unit: one softened dipole term from two particles, worked out with a
// shared multiplier, a bit-serial square root and a bit-serial divider.
// Depends on sdp_pkg.
`timescale 1ns / 1ps

module sdp_pair import sdp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  vec_t              pos_i,
  input  vec_t              pos_j,
  input  vec_t              vort_j,
  input  logic [EPS2_W-1:0] eps_sq,
  output logic              done,
  output term_t             term
);

  localparam int DCNT_W = $clog2(Q_W + Q1_SHIFT);

  typedef enum logic [2:0] {
    P_IDLE, P_MUL, P_ROOT0, P_ROOT, P_DIVI, P_DIV, P_DONE
  } pstate_t;

  pstate_t state;

  logic signed [DIFF_W-1:0] dx, dy, dz;
  vec_t                     vj;
  logic [2:0]               step;
  logic signed [PROD_W-1:0] prod;
  logic [R2_W-1:0]          r2;
  logic signed [DOT_W-1:0]  dot;
  logic [DOT_W-1:0]         ad;
  logic                     neg;
  logic [R2_W-1:0]          x_rem, root, rbit;
  logic [Q_W-1:0]           dnum, dq;
  logic [R2_W-1:0]          dden, drem;
  logic [DCNT_W-1:0]        dcnt;
  logic                     phase, clip;

  logic signed [DIFF_W-1:0] ma, mb;
  logic [R2_W:0]            rsum, rsh, rdiff;
  logic                     root_ge, div_ge, over;
  logic [R2_W-1:0]          rnew;
  logic [Q_W:0]             qn;

  always_comb begin
    case (step)
      3'd0:    begin ma = dx; mb = dx; end
      3'd1:    begin ma = dy; mb = dy; end
      3'd2:    begin ma = dz; mb = dz; end
      3'd3:    begin ma = dx; mb = $signed({vj.x[COORD_W-1], vj.x}); end
      3'd4:    begin ma = dy; mb = $signed({vj.y[COORD_W-1], vj.y}); end
      3'd5:    begin ma = dz; mb = $signed({vj.z[COORD_W-1], vj.z}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign rsum    = {1'b0, root} + {1'b0, rbit};
  assign root_ge = {1'b0, x_rem} >= rsum;

  assign rsh    = {drem, dnum[Q_W-1]};
  assign div_ge = rsh >= {1'b0, dden};
  assign rdiff  = rsh - {1'b0, dden};
  assign rnew   = div_ge ? rdiff[R2_W-1:0] : rsh[R2_W-1:0];
  assign qn     = {dq, div_ge};
  assign over   = qn > {1'b0, TERM_CAP};

  assign done      = (state == P_DONE);
  assign term.mag  = dq;
  assign term.neg  = neg;
  assign term.clip = clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      case (state)
        P_IDLE: begin
          if (start) begin
            dx <= $signed({pos_i.x[COORD_W-1], pos_i.x}) -
                  $signed({pos_j.x[COORD_W-1], pos_j.x});
            dy <= $signed({pos_i.y[COORD_W-1], pos_i.y}) -
                  $signed({pos_j.y[COORD_W-1], pos_j.y});
            dz <= $signed({pos_i.z[COORD_W-1], pos_i.z}) -
                  $signed({pos_j.z[COORD_W-1], pos_j.z});
            vj    <= vort_j;
            step  <= '0;
            r2    <= R2_W'(eps_sq);
            dot   <= '0;
            clip  <= 1'b0;
            phase <= 1'b0;
            state <= P_MUL;
          end
        end
        P_MUL: begin
          // multiply one product per cycle, add the previous one
          if (step != 3'd6) begin
            prod <= ma * mb;
          end
          if (step != 3'd0) begin
            if (step <= 3'd3) begin
              r2 <= r2 + $unsigned(prod);
            end else begin
              dot <= dot + prod;
            end
          end
          if (step == 3'd6) begin
            state <= P_ROOT0;
          end else begin
            step <= step + 3'd1;
          end
        end
        P_ROOT0: begin
          // a coincident pair has a zero dot product, so neg is clear there
          neg <= dot[DOT_W-1];
          ad  <= dot[DOT_W-1] ? $unsigned(-dot) : $unsigned(dot);
          if (r2 == '0) begin
            // coincident pair with no softening adds nothing
            dq    <= '0;
            state <= P_DONE;
          end else begin
            x_rem <= r2;
            root  <= '0;
            rbit  <= R2_W'(1) << (2 * (ROOT_W - 1));
            state <= P_ROOT;
          end
        end
        P_ROOT: begin
          if (root_ge) begin
            x_rem <= x_rem - rsum[R2_W-1:0];
            root  <= (root >> 1) + rbit;
          end else begin
            root <= root >> 1;
          end
          rbit <= rbit >> 2;
          if (rbit[0]) begin
            state <= P_DIVI;
          end
        end
        P_DIVI: begin
          drem <= '0;
          dq   <= '0;
          if (!phase) begin
            dnum <= Q_W'(ad);
            dden <= R2_W'(root[ROOT_W-1:0]);
            dcnt <= DCNT_W'(Q_W + Q1_SHIFT - 1);
          end else begin
            dnum <= dq;
            dden <= r2;
            dcnt <= DCNT_W'(Q_W + FRAC_BITS - 1);
          end
          state <= P_DIV;
        end
        P_DIV: begin
          dnum <= dnum << 1;
          drem <= rnew;
          if (over || dcnt == '0) begin
            if (over) begin
              dq   <= TERM_CAP;
              clip <= 1'b1;
            end else begin
              dq <= qn[Q_W-1:0];
            end
            phase <= 1'b1;
            state <= phase ? P_DONE : P_DIVI;
          end else begin
            dq   <= qn[Q_W-1:0];
            dcnt <= dcnt - DCNT_W'(1);
          end
        end
        P_DONE: begin
          state <= P_IDLE;
        end
        default: begin
          state <= P_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/softened_dipole_potential.sv
// Top level of the softened dipole potential block: particle store, row and
// column sequencer, accumulation, 1/(4 pi) scaling and the result register.
// Depends on sdp_pkg, sdp_ram and sdp_pair.
//
//   channel   dir  handshake           beat contents
//   s_*       in   s_tvalid/s_tready   tdata: pos_x, pos_y, pos_z, vort_x,
//                                       vort_y, vort_z; tlast: last_particle
//   m_*       out  m_tvalid/m_tready   tdata: potential, particle_index;
//                                       tlast: last_result; tuser: saturated,
//                                       dropped
//   cfg_*     in   cfg_we              softening_length
//
// Loading accepts one beat per cycle. After the last beat of a set of n
// particles the block works out n*(n-1) pair terms in the pair unit, each
// with 25 square root steps and two bit-serial divisions of 81 and
// 57+FRAC_BITS steps, and then scales and emits one result per particle.
// Reset clears the set and loads the softening register with EPS_RESET; the
// store keeps no reset. A stalled result waits in the output register while
// the sequencer holds; the last result of a set may wait there while loading
// of the next set goes on.
`timescale 1ns / 1ps

module softened_dipole_potential import sdp_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [143:0]       s_tdata,   // pos_x, pos_y, pos_z, vort_x, vort_y, vort_z
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [47:0]        m_tdata,   // potential, particle_index, zero pad
  output logic               m_tlast,
  output logic [1:0]         m_tuser,   // saturated, dropped
  input  logic               cfg_we,
  input  logic [EPS_W-1:0]   cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_ROW_RD, S_ROW_WAIT, S_COL_RD, S_COL_WAIT, S_PAIR,
    S_ABS, S_MUL, S_SUM, S_EMIT
  } state_t;

  state_t state;

  logic [EPS_W-1:0]  eps;
  logic [EPS2_W-1:0] eps_sq;

  logic [CNT_W-1:0] cnt, n;
  logic             ovf;
  logic [IDX_W-1:0] row, col;
  vec_t             pos_i;
  logic signed [ACC_W-1:0] acc;
  logic             sat;
  logic             acc_pos;
  logic [MAG_W-1:0] mabs;
  logic [HI_W+INV_W-1:0] ph;
  logic [32+INV_W-1:0]   pl;
  logic [SCALE_W-1:0]    mag;

  logic [POT_W-1:0]     out_pot;
  logic [IDX_OUT_W-1:0] out_idx;
  logic                 out_last, out_sat, out_drop;

  logic             in_beat, room, row_last, col_last, out_free;
  logic             ram_we;
  logic [IDX_W-1:0] raddr;
  entry_t           rd_entry;
  logic             pair_start, pair_done;
  term_t            term;
  logic signed [ACC_W-1:0] tval;
  logic [POT_W-1:0] pot_val;
  logic             pot_clip;

  assign s_tready = (state == S_LOAD);
  assign in_beat  = s_tvalid && s_tready;
  assign room     = cnt < CNT_W'(MAX_PARTICLES);
  assign ram_we   = in_beat && room;
  assign raddr    = (state == S_ROW_RD) ? row : col;
  assign row_last = (CNT_W'(row) + CNT_W'(1)) == n;
  assign col_last = (CNT_W'(col) + CNT_W'(1)) == n;
  assign out_free = !m_tvalid || m_tready;
  assign pair_start = (state == S_COL_WAIT);
  assign tval = $signed({{(ACC_W-Q_W){1'b0}}, term.mag});

  sdp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata (s_tdata),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  sdp_pair #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pair (
    .clk    (clk),
    .rst    (rst),
    .start  (pair_start),
    .pos_i  (pos_i),
    .pos_j  (rd_entry.pos),
    .vort_j (rd_entry.vort),
    .eps_sq (eps_sq),
    .done   (pair_done),
    .term   (term)
  );

  // Clamp the scaled magnitude; a positive sum gives a negative potential.
  always_comb begin
    pot_clip = 1'b0;
    if (acc_pos) begin
      if (mag > POT_NEG_LIM) begin
        pot_val  = POT_NEG_LIM[POT_W-1:0];
        pot_clip = 1'b1;
      end else begin
        pot_val = -mag[POT_W-1:0];
      end
    end else begin
      if (mag > POT_POS_LIM) begin
        pot_val  = POT_POS_LIM[POT_W-1:0];
        pot_clip = 1'b1;
      end else begin
        pot_val = mag[POT_W-1:0];
      end
    end
  end

  // Softening register and its square; the user must write it only while idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
    end else if (cfg_we) begin
      eps <= cfg_wdata;
    end
    eps_sq <= eps * eps;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      cnt      <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the result once taken; S_EMIT handles the register itself
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_beat) begin
            // store while there is room, drop and flag the rest
            if (room) begin
              cnt <= cnt + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              n     <= room ? cnt + CNT_W'(1) : cnt;
              row   <= '0;
              state <= S_ROW_RD;
            end
          end
        end
        S_ROW_RD: begin
          acc   <= '0;
          sat   <= 1'b0;
          col   <= '0;
          state <= S_ROW_WAIT;
        end
        S_ROW_WAIT: begin
          pos_i <= rd_entry.pos;
          state <= S_COL_RD;
        end
        S_COL_RD: begin
          // skip the self term
          if (col == row) begin
            if (col_last) begin
              state <= S_ABS;
            end else begin
              col <= col + IDX_W'(1);
            end
          end else begin
            state <= S_COL_WAIT;
          end
        end
        S_COL_WAIT: begin
          state <= S_PAIR;
        end
        S_PAIR: begin
          if (pair_done) begin
            acc <= term.neg ? acc - tval : acc + tval;
            sat <= sat | term.clip;
            if (col_last) begin
              state <= S_ABS;
            end else begin
              col   <= col + IDX_W'(1);
              state <= S_COL_RD;
            end
          end
        end
        S_ABS: begin
          acc_pos <= (acc > 0);
          mabs    <= acc[ACC_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
          state   <= S_MUL;
        end
        S_MUL: begin
          ph    <= mabs[MAG_W-1:32] * INV_4PI_Q32;
          pl    <= mabs[31:0] * INV_4PI_Q32;
          state <= S_SUM;
        end
        S_SUM: begin
          // round half up on the low partial product
          mag <= SCALE_W'(ph) +
                 SCALE_W'((pl + (32+INV_W)'(64'h80000000)) >> 32);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_pot  <= pot_val;
            out_idx  <= IDX_OUT_W'(row);
            out_last <= row_last;
            out_sat  <= sat | pot_clip;
            out_drop <= ovf;
            if (row_last) begin
              cnt   <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              row   <= row + IDX_W'(1);
              state <= S_ROW_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign m_tdata = {2'b00, out_idx, out_pot};
  assign m_tlast = out_last;
  assign m_tuser = {out_drop, out_sat};

  // Store fill never passes capacity.
  assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_PARTICLES))
    else $error("particle count beyond capacity");

  // A beat other than the last that finds the store full must raise the drop flag.
  assert property (@(posedge clk) disable iff (rst)
    (in_beat && !room && !s_tlast) |=> ovf)
    else $error("overflow not recorded");

  // A new result is only loaded into a free output register.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && m_tvalid && !m_tready) |=> (state == S_EMIT))
    else $error("result register overwritten");

endmodule
